[sv/hsvbb_pkg.sv]
// Shared types and constants for the HSV color blob bounding box.
package hsvbb_pkg;

   localparam int unsigned CoordW = 11;
   localparam int unsigned SizeW  = 12;
   localparam int unsigned CountW = 23;
   localparam logic [CountW-1:0] CountMax = '1;

   typedef enum logic [2:0] {
      REG_WINDOW_X     = 3'd0,
      REG_WINDOW_Y     = 3'd1,
      REG_WINDOW_W     = 3'd2,
      REG_WINDOW_H     = 3'd3,
      REG_HSV_LOW      = 3'd4,
      REG_HSV_HIGH     = 3'd5,
      REG_PIXEL_FORMAT = 3'd6,
      REG_MIN_PIXELS   = 3'd7
   } reg_index_type;

   // Which channel holds the maximum, which picks the hue offset.
   typedef enum logic [1:0] {
      HUE_RED   = 2'd0,
      HUE_GREEN = 2'd1,
      HUE_BLUE  = 2'd2
   } hue_sel_type;

   // Classified pixel from the front part, handed to the divider back part.
   typedef struct packed {
      logic              in_win;
      logic              last;
      logic [CoordW-1:0] x;
      logic [CoordW-1:0] y;
      logic [7:0]        v;
      logic [7:0]        d;
      hue_sel_type       hsel;
      logic              hneg;
      logic [7:0]        hdiff;  // magnitude of the hue difference
   } pix_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_DIV  = 2'd1,
      ST_ACC  = 2'd2,
      ST_OUT  = 2'd3
   } back_state_type;

   typedef struct packed {
      logic              found;
      logic [CoordW-1:0] box_x;
      logic [CoordW-1:0] box_y;
      logic [SizeW-1:0]  box_width;
      logic [SizeW-1:0]  box_height;
      logic [CoordW-1:0] mid_x;
      logic [CoordW-1:0] mid_y;
   } result_type;

endpackage

[sv/hsv_color_blob_bounding_box.sv]
// Top level of the HSV color blob bounding box.
// Pixel items enter through req_, are window-tested and classified in the front part,
// then queued two deep for the back part, which derives S and H with a shared
// one-bit-per-cycle divider. Each pixel holds the back part from when it is taken,
// through the division, to the bound test and box update, so the back part takes no
// new pixel until it is through with the last. The frame-end pixel yields one rsp_
// item, offered once that pixel's box update is done and held until rsp_ready (found
// 0 and all zero if count does not exceed min_pixels). Registers are written by index
// over csr_; write only while no item is in flight.
module hsv_color_blob_bounding_box #(
   parameter int unsigned MAX_WIDTH  = 2048,
   parameter int unsigned MAX_HEIGHT = 2048
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_byte0,
   input  logic [7:0]  req_byte1,
   input  logic [7:0]  req_byte2,
   input  logic [10:0] req_x_pos,
   input  logic [10:0] req_y_pos,
   input  logic        req_last_in_frame,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_found,
   output logic [10:0] rsp_box_x,
   output logic [10:0] rsp_box_y,
   output logic [11:0] rsp_box_width,
   output logic [11:0] rsp_box_height,
   output logic [10:0] rsp_center_x,
   output logic [10:0] rsp_center_y
);
   logic [10:0] window_x_ff, window_y_ff;
   logic [11:0] window_w_ff, window_h_ff;
   logic [23:0] hsv_lower_ff, hsv_upper_ff;
   logic        format_ff;
   logic [22:0] min_pixels_ff;
   hsvbb_pkg::pix_type pix, q_data;
   hsvbb_pkg::result_type res;
   logic q_valid, q_ready;

   assign csr_ready = 1'b1;

   // Register file.
   always_ff @(posedge clock) begin
      if (reset) begin
         window_x_ff <= '0; window_y_ff <= '0;
         window_w_ff <= 12'd2048; window_h_ff <= 12'd2048;
         hsv_lower_ff <= '0; hsv_upper_ff <= '1;
         format_ff <= 1'b0; min_pixels_ff <= 23'd200;
      end else if (csr_valid) begin
         unique case (hsvbb_pkg::reg_index_type'(csr_index))
            hsvbb_pkg::REG_WINDOW_X:     window_x_ff <= csr_data[10:0];
            hsvbb_pkg::REG_WINDOW_Y:     window_y_ff <= csr_data[10:0];
            hsvbb_pkg::REG_WINDOW_W:     window_w_ff <= csr_data[11:0];
            hsvbb_pkg::REG_WINDOW_H:     window_h_ff <= csr_data[11:0];
            hsvbb_pkg::REG_HSV_LOW:      hsv_lower_ff <= csr_data[23:0];
            hsvbb_pkg::REG_HSV_HIGH:     hsv_upper_ff <= csr_data[23:0];
            hsvbb_pkg::REG_PIXEL_FORMAT: format_ff <= csr_data[0];
            default:                     min_pixels_ff <= csr_data[22:0];
         endcase
      end
   end

   hsvbb_front #(.MaxWidth(MAX_WIDTH), .MaxHeight(MAX_HEIGHT)) u_front (
      .format_rgb(format_ff), .window_x(window_x_ff), .window_y(window_y_ff),
      .window_w(window_w_ff), .window_h(window_h_ff),
      .byte0(req_byte0), .byte1(req_byte1), .byte2(req_byte2),
      .x_pos(req_x_pos), .y_pos(req_y_pos), .last_in_frame(req_last_in_frame),
      .pix(pix)
   );

   hsvbb_fifo u_fifo (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready), .in_data(pix),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
   );

   hsvbb_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
      .hsv_lower(hsv_lower_ff), .hsv_upper(hsv_upper_ff), .min_pixels(min_pixels_ff),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_data(res)
   );

   assign rsp_found      = res.found;
   assign rsp_box_x      = res.box_x;
   assign rsp_box_y      = res.box_y;
   assign rsp_box_width  = res.box_width;
   assign rsp_box_height = res.box_height;
   assign rsp_center_x   = res.mid_x;
   assign rsp_center_y   = res.mid_y;

`ifndef SYNTHESIS
   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_box_width == 12'd0 && rsp_box_x == 11'd0)
      else $error("not-found result carries a box");
   a_found_size: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found |-> rsp_box_width != 12'd0 && rsp_box_height != 12'd0)
      else $error("found result with empty box");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_box_x))
      else $error("result dropped while stalled");
`endif
endmodule

[sv/hsvbb_front.sv]
// Front part: window test and color classification of each pixel item.
module hsvbb_front #(
   parameter int unsigned MaxWidth  = 2048,
   parameter int unsigned MaxHeight = 2048
) (
   input  logic                          format_rgb,
   input  logic [hsvbb_pkg::CoordW-1:0]  window_x,
   input  logic [hsvbb_pkg::CoordW-1:0]  window_y,
   input  logic [hsvbb_pkg::SizeW-1:0]   window_w,
   input  logic [hsvbb_pkg::SizeW-1:0]   window_h,
   input  logic [7:0]                    byte0,
   input  logic [7:0]                    byte1,
   input  logic [7:0]                    byte2,
   input  logic [hsvbb_pkg::CoordW-1:0]  x_pos,
   input  logic [hsvbb_pkg::CoordW-1:0]  y_pos,
   input  logic                          last_in_frame,
   output hsvbb_pkg::pix_type            pix
);
   logic [7:0] r, g, b, mx, mn;
   logic [hsvbb_pkg::SizeW:0] ox, oy;
   logic in_x, in_y;

   // Window test with clipping at the frame edge.
   always_comb begin
      ox = {2'b0, x_pos} - {2'b0, window_x};
      oy = {2'b0, y_pos} - {2'b0, window_y};
      in_x = (x_pos >= window_x) && (ox < {1'b0, window_w})
             && (32'(x_pos) < MaxWidth);
      in_y = (y_pos >= window_y) && (oy < {1'b0, window_h})
             && (32'(y_pos) < MaxHeight);
   end

   // Pick channels, max and min, and the hue sector.
   always_comb begin
      g = byte1;
      r = format_rgb ? byte0 : byte2;
      b = format_rgb ? byte2 : byte0;
      mx = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      mn = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      pix.in_win = in_x && in_y;
      pix.last   = last_in_frame;
      pix.x      = x_pos;
      pix.y      = y_pos;
      pix.v      = mx;
      pix.d      = mx - mn;
      if (mx == r) begin
         pix.hsel = hsvbb_pkg::HUE_RED;
         pix.hneg = g < b;
         pix.hdiff = (g < b) ? b - g : g - b;
      end else if (mx == g) begin
         pix.hsel = hsvbb_pkg::HUE_GREEN;
         pix.hneg = b < r;
         pix.hdiff = (b < r) ? r - b : b - r;
      end else begin
         pix.hsel = hsvbb_pkg::HUE_BLUE;
         pix.hneg = r < g;
         pix.hdiff = (r < g) ? g - r : r - g;
      end
   end
endmodule

[sv/hsvbb_fifo.sv]
// Short queue between the front and back parts.
module hsvbb_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  hsvbb_pkg::pix_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output hsvbb_pkg::pix_type out_data
);
   hsvbb_pkg::pix_type mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   // Advance pointers and count.
   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= in_data;
      end
   end
endmodule

[sv/hsvbb_back.sv]
// Back part: serial S and H division, bound test, box accumulation, result.
module hsvbb_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  hsvbb_pkg::pix_type            in_data,
   input  logic [23:0]                   hsv_lower,
   input  logic [23:0]                   hsv_upper,
   input  logic [hsvbb_pkg::CountW-1:0]  min_pixels,
   output logic                          out_valid,
   input  logic                          out_ready,
   output hsvbb_pkg::result_type         out_data
);
   localparam int unsigned QW = 16;  // quotient bits, numerators below 2^16
   localparam int unsigned CoordWL = hsvbb_pkg::CoordW;

   hsvbb_pkg::back_state_type state_ff, state_in;
   hsvbb_pkg::pix_type pix_ff;
   logic [15:0] snum_ff, snum_in, hnum_ff, hnum_in;
   logic [8:0]  srem_ff, srem_in, hrem_ff, hrem_in;
   logic [15:0] squo_ff, squo_in, hquo_ff, hquo_in;
   logic [3:0]  step_ff, step_in;
   logic [CoordWL-1:0] min_col_ff, max_col_ff, min_row_ff, max_row_ff;
   logic [hsvbb_pkg::CountW-1:0] count_ff;
   hsvbb_pkg::result_type res_in;
   logic [8:0]  stry, htry;
   logic [7:0]  h, s;
   logic [8:0]  hh;
   logic        hit, take;
   logic [hsvbb_pkg::SizeW-1:0] w, ht;

   assign in_ready  = state_ff == hsvbb_pkg::ST_IDLE;
   assign take      = in_valid && in_ready;
   assign out_valid = state_ff == hsvbb_pkg::ST_OUT;
   assign out_data  = res_in;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hsvbb_pkg::ST_IDLE: if (take) state_in = hsvbb_pkg::ST_DIV;
         hsvbb_pkg::ST_DIV:  if (step_ff == 4'd0) state_in = hsvbb_pkg::ST_ACC;
         hsvbb_pkg::ST_ACC:  state_in = pix_ff.last ? hsvbb_pkg::ST_OUT
                                                    : hsvbb_pkg::ST_IDLE;
         hsvbb_pkg::ST_OUT:  if (out_ready) state_in = hsvbb_pkg::ST_IDLE;
         default:            state_in = hsvbb_pkg::ST_IDLE;
      endcase
   end

   // Restoring division, one quotient bit per cycle for S and H together.
   always_comb begin
      stry = {srem_ff[7:0], snum_ff[15]} - {1'b0, pix_ff.v};
      htry = {hrem_ff[7:0], hnum_ff[15]} - {1'b0, pix_ff.d};
      snum_in = snum_ff; hnum_in = hnum_ff; srem_in = srem_ff; hrem_in = hrem_ff;
      squo_in = squo_ff; hquo_in = hquo_ff; step_in = step_ff;
      if (take) begin
         snum_in = 16'(in_data.d) * 16'd255;
         hnum_in = 16'(in_data.hdiff) * 16'd30;
         srem_in = '0; hrem_in = '0; squo_in = '0; hquo_in = '0;
         step_in = 4'(QW - 1);
      end else if (state_ff == hsvbb_pkg::ST_DIV) begin
         snum_in = {snum_ff[14:0], 1'b0};
         hnum_in = {hnum_ff[14:0], 1'b0};
         if (!stry[8]) begin
            srem_in = stry; squo_in = {squo_ff[14:0], 1'b1};
         end else begin
            srem_in = {srem_ff[7:0], snum_ff[15]}; squo_in = {squo_ff[14:0], 1'b0};
         end
         if (!htry[8]) begin
            hrem_in = htry; hquo_in = {hquo_ff[14:0], 1'b1};
         end else begin
            hrem_in = {hrem_ff[7:0], hnum_ff[15]}; hquo_in = {hquo_ff[14:0], 1'b0};
         end
         step_in = step_ff - 4'd1;
      end
   end

   // Hue from quotient and remainder; negative side rounds toward minus infinity.
   always_comb begin
      s = (pix_ff.v == 8'd0) ? 8'd0 : squo_ff[7:0];
      hh = (pix_ff.hneg && hrem_ff != 9'd0) ? 9'(hquo_ff) + 9'd1 : 9'(hquo_ff);
      if (pix_ff.d == 8'd0) begin
         h = 8'd0;
      end else begin
         unique case (pix_ff.hsel)
            hsvbb_pkg::HUE_RED:   h = pix_ff.hneg ? 8'(9'd180 - hh) : hquo_ff[7:0];
            hsvbb_pkg::HUE_GREEN: h = pix_ff.hneg ? 8'(9'd60 - hh)
                                                  : 8'(9'd60 + 9'(hquo_ff));
            default:              h = pix_ff.hneg ? 8'(9'd120 - hh)
                                                  : 8'(9'd120 + 9'(hquo_ff));
         endcase
      end
      hit = pix_ff.in_win
            && h >= hsv_lower[7:0] && h <= hsv_upper[7:0]
            && s >= hsv_lower[15:8] && s <= hsv_upper[15:8]
            && pix_ff.v >= hsv_lower[23:16] && pix_ff.v <= hsv_upper[23:16];
   end

   // Form the frame result from the box registers, stable while offered.
   always_comb begin
      w  = {1'b0, max_col_ff} - {1'b0, min_col_ff} + 12'd1;
      ht = {1'b0, max_row_ff} - {1'b0, min_row_ff} + 12'd1;
      res_in = '0;
      if (count_ff > min_pixels) begin
         res_in.found      = 1'b1;
         res_in.box_x      = min_col_ff;
         res_in.box_y      = min_row_ff;
         res_in.box_width  = w;
         res_in.box_height = ht;
         res_in.mid_x      = min_col_ff + w[CoordWL:1];
         res_in.mid_y      = min_row_ff + ht[CoordWL:1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hsvbb_pkg::ST_IDLE;
         count_ff <= '0;
         min_col_ff <= '0; max_col_ff <= '0; min_row_ff <= '0; max_row_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == hsvbb_pkg::ST_ACC) begin
            if (hit) begin
               if (count_ff == '0) begin
                  min_col_ff <= pix_ff.x; max_col_ff <= pix_ff.x;
                  min_row_ff <= pix_ff.y; max_row_ff <= pix_ff.y;
               end else begin
                  if (pix_ff.x < min_col_ff) min_col_ff <= pix_ff.x;
                  if (pix_ff.x > max_col_ff) max_col_ff <= pix_ff.x;
                  if (pix_ff.y < min_row_ff) min_row_ff <= pix_ff.y;
                  if (pix_ff.y > max_row_ff) max_row_ff <= pix_ff.y;
               end
               if (count_ff != hsvbb_pkg::CountMax) count_ff <= count_ff + 1'b1;
            end
         end else if (state_ff == hsvbb_pkg::ST_OUT && out_ready) begin
            count_ff <= '0;
            min_col_ff <= '0; max_col_ff <= '0; min_row_ff <= '0; max_row_ff <= '0;
         end
      end
   end

   // Hold pixel and divider data.
   always_ff @(posedge clock) begin
      if (take) pix_ff <= in_data;
      snum_ff <= snum_in; hnum_ff <= hnum_in;
      srem_ff <= srem_in; hrem_ff <= hrem_in;
      squo_ff <= squo_in; hquo_ff <= hquo_in;
      step_ff <= step_in;
   end
endmodule
